### hw/rtl/bcr_pkg.sv
// Shared constants, types and condition logic for the branch/call/return unit.
package bcr_pkg;

    localparam int MEM_BYTES   = 4096;              // stack memory size, power of two
    localparam int ADDR_W      = $clog2(MEM_BYTES);
    localparam int WORD_W      = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int FALL_OFFSET = 9;                 // instruction length of jump/call
    localparam int FRAME_BYTES = 8;                 // one return address on the stack

    // action codes
    localparam logic [1:0] ACT_JUMP = 2'd0;
    localparam logic [1:0] ACT_CALL = 2'd1;
    localparam logic [1:0] ACT_RET  = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // jump condition codes; all others never taken
    localparam logic [3:0] CC_ALWAYS = 4'd0;
    localparam logic [3:0] CC_LE     = 4'd1;
    localparam logic [3:0] CC_L      = 4'd2;
    localparam logic [3:0] CC_E      = 4'd3;
    localparam logic [3:0] CC_NE     = 4'd4;
    localparam logic [3:0] CC_GE     = 4'd5;
    localparam logic [3:0] CC_G      = 4'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_START   = 2'd1;

    // operations of the shared address adder
    typedef enum logic [1:0] {
        ADD_PC_FALL,
        SUB_SP_FRAME,
        ADD_SP_FRAME
    } addop_t;

    // write port of the stack memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    function automatic logic cond_holds(logic [3:0] code, logic zf, logic sf, logic of);
        logic lt;
        logic res;
        lt = sf ^ of;
        case (code)
            CC_ALWAYS: res = 1'b1;
            CC_LE:     res = lt | zf;
            CC_L:      res = lt;
            CC_E:      res = zf;
            CC_NE:     res = ~zf;
            CC_GE:     res = ~lt;
            CC_G:      res = ~lt & ~zf;
            default:   res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/branch_call_return_unit.sv
// Top level of the branch/call/return unit: sequencer, state registers and ports.
//
// Takes one control-flow beat at a time (jump, call or return) and returns the
// new PC, the new stack pointer and a taken flag. A jump steps through PC+9 and
// finish; a call through PC+9, SP-8, byte stores and finish; a return through
// byte reads, a tail step, SP+8 and finish; an unused action straight to finish.
// The byte-wide stack memory moves the eight bytes of a return address one per
// cycle, and the single shared 64-bit adder forms PC+9 and SP-/+8 in cycles of
// their own. The result sits in an output register, so the next beat may be
// taken while it waits. After reset the stack memory is cleared one byte per
// cycle, during which s_tready stays low; configuration writes are taken at any
// time and reload PC or SP at once. Stack addresses wrap modulo the memory size.
module branch_call_return_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [71:0]                        s_tdata,   // cond_code[3:0], target[67:4],
                                                          // zero_flag[68], sign_flag[69],
                                                          // overflow_flag[70], zero[71]
    input  logic [1:0]                         s_tuser,   // action[1:0]
    // result beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [135:0]                       m_tdata,   // next_pc[63:0],
                                                          // new_stack_pointer[127:64],
                                                          // taken[128], zero[135:129]
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcr_pkg::WORD_W-1:0]         cfg_data
);

    localparam int W = bcr_pkg::WORD_W;
    localparam int A = bcr_pkg::ADDR_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FALL,
        ST_SP_DEC,
        ST_CALL_WR,
        ST_RET_RD,
        ST_RET_TAIL,
        ST_SP_INC,
        ST_FINISH
    } state_t;

    state_t         state_reg,    state_next;
    logic [A-1:0]   clr_addr_reg, clr_addr_next;
    logic [2:0]     cnt_reg,      cnt_next;
    logic           rd_pend_reg,  rd_pend_next;
    logic [W-1:0]   pc_reg,       pc_next;
    logic [W-1:0]   sp_reg,       sp_next;
    logic [1:0]     act_reg,      act_next;
    logic [3:0]     cc_reg,       cc_next;
    logic [W-1:0]   tgt_reg,      tgt_next;
    logic           zf_reg,       zf_next;
    logic           sf_reg,       sf_next;
    logic           of_reg,       of_next;
    logic [W-1:0]   fall_reg,     fall_next;      // PC+9, shifted out byte by byte on a call
    logic [W-1:0]   frame_sp_reg, frame_sp_next;  // stack pointer after this beat
    logic [W-1:0]   ret_reg,      ret_next;       // return address gathered from memory
    logic           m_tvalid_reg, m_tvalid_next;
    logic [W-1:0]   out_pc_reg,   out_pc_next;
    logic [W-1:0]   out_sp_reg,   out_sp_next;
    logic           out_tk_reg,   out_tk_next;

    bcr_pkg::addop_t  add_op;
    logic [W-1:0]     add_sum;
    bcr_pkg::mem_wr_t mem_wr;
    logic [A-1:0]     mem_raddr;
    logic [7:0]       mem_rdata;
    logic             in_fire;
    logic             out_free;
    logic             jump_taken;

    bcr_adder u_adder (
        .op  (add_op),
        .pc  (pc_reg),
        .sp  (sp_reg),
        .sum (add_sum)
    );

    bcr_stack_mem u_mem (
        .aclk  (aclk),
        .wr    (mem_wr),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid & s_tready;
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign jump_taken = bcr_pkg::cond_holds(cc_reg, zf_reg, sf_reg, of_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_tk_reg, out_sp_reg, out_pc_reg};

    // adder operation follows the sequencer step
    always_comb begin
        case (state_reg)
            ST_SP_DEC: add_op = bcr_pkg::SUB_SP_FRAME;
            ST_SP_INC: add_op = bcr_pkg::ADD_SP_FRAME;
            default:   add_op = bcr_pkg::ADD_PC_FALL;
        endcase
    end

    // memory ports: zero sweep after reset, byte stores on a call
    always_comb begin
        mem_wr.we   = 1'b0;
        mem_wr.addr = frame_sp_reg[A-1:0] + A'(cnt_reg);
        mem_wr.data = fall_reg[7:0];
        if (state_reg == ST_CLEAR) begin
            mem_wr.we   = 1'b1;
            mem_wr.addr = clr_addr_reg;
            mem_wr.data = 8'd0;
        end else if (state_reg == ST_CALL_WR) begin
            mem_wr.we   = 1'b1;
        end
    end

    assign mem_raddr = sp_reg[A-1:0] + A'(cnt_reg);

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cnt_next      = cnt_reg;
        rd_pend_next  = 1'b0;
        pc_next       = pc_reg;
        sp_next       = sp_reg;
        act_next      = act_reg;
        cc_next       = cc_reg;
        tgt_next      = tgt_reg;
        zf_next       = zf_reg;
        sf_next       = sf_reg;
        of_next       = of_reg;
        fall_next     = fall_reg;
        frame_sp_next = frame_sp_reg;
        ret_next      = ret_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        out_pc_next   = out_pc_reg;
        out_sp_next   = out_sp_reg;
        out_tk_next   = out_tk_reg;

        // read data lands in the cycle after its address; little-endian gather
        if (rd_pend_reg) begin
            ret_next = {mem_rdata, ret_reg[W-1:8]};
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == {A{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    act_next = s_tuser;
                    cc_next  = s_tdata[3:0];
                    tgt_next = s_tdata[67:4];
                    zf_next  = s_tdata[68];
                    sf_next  = s_tdata[69];
                    of_next  = s_tdata[70];
                    cnt_next = 3'd0;
                    case (s_tuser)
                        bcr_pkg::ACT_JUMP: state_next = ST_FALL;
                        bcr_pkg::ACT_CALL: state_next = ST_FALL;
                        bcr_pkg::ACT_RET:  state_next = ST_RET_RD;
                        default:           state_next = ST_FINISH;
                    endcase
                end
            end
            ST_FALL: begin
                fall_next = add_sum;
                if (act_reg == bcr_pkg::ACT_CALL) begin
                    state_next = ST_SP_DEC;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SP_DEC: begin
                frame_sp_next = add_sum;
                state_next    = ST_CALL_WR;
            end
            ST_CALL_WR: begin
                fall_next = fall_reg >> 8;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 3'd7) begin
                    state_next = ST_FINISH;
                end
            end
            ST_RET_RD: begin
                rd_pend_next = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == 3'd7) begin
                    state_next = ST_RET_TAIL;
                end
            end
            ST_RET_TAIL: begin
                state_next = ST_SP_INC;
            end
            ST_SP_INC: begin
                frame_sp_next = add_sum;
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    case (act_reg)
                        bcr_pkg::ACT_JUMP: begin
                            pc_next     = jump_taken ? tgt_reg : fall_reg;
                            out_tk_next = jump_taken;
                        end
                        bcr_pkg::ACT_CALL: begin
                            pc_next     = tgt_reg;
                            sp_next     = frame_sp_reg;
                            out_tk_next = 1'b1;
                        end
                        bcr_pkg::ACT_RET: begin
                            pc_next     = ret_reg;
                            sp_next     = frame_sp_reg;
                            out_tk_next = 1'b1;
                        end
                        default: begin
                            out_tk_next = 1'b0;
                        end
                    endcase
                    out_pc_next = pc_next;
                    out_sp_next = sp_next;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // register writes reload the live PC / SP at once
        if (cfg_valid) begin
            case (cfg_index)
                bcr_pkg::CFG_START_ADDRESS: pc_next = cfg_data;
                bcr_pkg::CFG_STACK_START:   sp_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cnt_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            pc_reg       <= '0;
            sp_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cnt_reg      <= cnt_next;
            rd_pend_reg  <= rd_pend_next;
            pc_reg       <= pc_next;
            sp_reg       <= sp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        act_reg      <= act_next;
        cc_reg       <= cc_next;
        tgt_reg      <= tgt_next;
        zf_reg       <= zf_next;
        sf_reg       <= sf_next;
        of_reg       <= of_next;
        fall_reg     <= fall_next;
        frame_sp_reg <= frame_sp_next;
        ret_reg      <= ret_next;
        out_pc_reg   <= out_pc_next;
        out_sp_reg   <= out_sp_next;
        out_tk_reg   <= out_tk_next;
    end

endmodule

### hw/rtl/bcr_adder.sv
// Shared 64-bit address adder: PC+9, SP-8 and SP+8.
module bcr_adder (
    input  bcr_pkg::addop_t                op,
    input  logic [bcr_pkg::WORD_W-1:0]     pc,
    input  logic [bcr_pkg::WORD_W-1:0]     sp,
    output logic [bcr_pkg::WORD_W-1:0]     sum
);

    logic [bcr_pkg::WORD_W-1:0] opa;
    logic [bcr_pkg::WORD_W-1:0] opb;

    always_comb begin
        case (op)
            bcr_pkg::ADD_PC_FALL: begin
                opa = pc;
                opb = bcr_pkg::WORD_W'(bcr_pkg::FALL_OFFSET);
            end
            bcr_pkg::SUB_SP_FRAME: begin
                opa = sp;
                opb = ~bcr_pkg::WORD_W'(bcr_pkg::FRAME_BYTES) + 1'b1;  // two's complement -8
            end
            bcr_pkg::ADD_SP_FRAME: begin
                opa = sp;
                opb = bcr_pkg::WORD_W'(bcr_pkg::FRAME_BYTES);
            end
            default: begin
                opa = pc;
                opb = '0;
            end
        endcase
    end

    assign sum = opa + opb;

endmodule

### hw/rtl/bcr_stack_mem.sv
// Byte-wide stack memory, one write and one registered read per cycle.
module bcr_stack_mem (
    input  logic                           aclk,
    input  bcr_pkg::mem_wr_t               wr,
    input  logic [bcr_pkg::ADDR_W-1:0]     raddr,
    output logic [7:0]                     rdata
);

    logic [7:0] mem [bcr_pkg::MEM_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bcr_checker.sv
// Port-level checks for the branch/call/return unit, bound to the top level.
module bcr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);

    // stack clear pass holds off input straight after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during stack clear");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat straight out of reset");

    // one beat at a time: never ready again in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous beat in flight");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

endmodule

bind branch_call_return_unit bcr_checker u_bcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/testbench.sv
// Self-checking testbench for the branch/call/return unit: directed table, then random beats.
module testbench;
    import bcr_pkg::*;

    // spare register indexes; a write there must leave PC and SP alone
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI   = 2'd3;
    // codes 7..15 are never taken
    localparam logic [3:0]           CC_NEVER_FIRST = 4'd7;
    localparam logic [3:0]           CC_NEVER_LAST  = 4'd15;
    localparam logic [WORD_W-1:0]    ALL_ONES       = '1;
    localparam int                   SETTLE_CYCLES  = 16;        // longer than a call or a return takes
    localparam int                   RUN_LIMIT      = 8_000_000; // watchdog limit in simulation time units

    typedef struct packed {
        logic [1:0]        action;
        logic [3:0]        cond_code;
        logic [WORD_W-1:0] target;
        logic              zero_flag;
        logic              sign_flag;
        logic              overflow_flag;
    } flow_cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] next_pc;
        logic [WORD_W-1:0] new_stack_pointer;
        logic              taken;
    } flow_result_t;

    // one row of stimulus; typed rows carry a result read straight off the spec
    typedef struct {
        flow_cmd_t    cmd;
        bit           typed;
        flow_result_t want;
    } stim_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [71:0]          s_tdata   = '0;   // cond_code, target, zero_flag, sign_flag,
                                            // overflow_flag, zero pad
    logic [1:0]           s_tuser   = ACT_JUMP; // action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [135:0]         m_tdata;          // next_pc, new_stack_pointer, taken, zero pad
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_START_ADDRESS;
    logic [WORD_W-1:0]    cfg_data  = '0;

    // predictor state: its own copy of the registers, PC, SP and the stack bytes
    logic [WORD_W-1:0]    shadow_start       = '0;
    logic [WORD_W-1:0]    shadow_stack_start = '0;
    logic [WORD_W-1:0]    shadow_pc          = '0;
    logic [WORD_W-1:0]    shadow_sp          = '0;
    logic [7:0]           shadow_stack [MEM_BYTES];

    flow_result_t         expected_flow_q [$];
    stim_row_t            directed_rows [$];
    int                   error_count    = 0;
    int                   send_idle_pct  = 34;
    int                   recv_idle_pct  = 87;

    always #10 aclk = ~aclk;

    branch_call_return_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // --------------------------------------------------------------------
    // Predictor
    // --------------------------------------------------------------------

    // does the jump condition hold for these flags
    function automatic logic branch_taken(logic [3:0] cc, logic zf, logic sf, logic of);
        logic less;
        less = (sf != of);
        case (cc)
            CC_ALWAYS: return 1'b1;
            CC_LE:     return less || zf;
            CC_L:      return less;
            CC_E:      return zf;
            CC_NE:     return !zf;
            CC_GE:     return !less;
            CC_G:      return !less && !zf;
            default:   return 1'b0;
        endcase
    endfunction

    // advance the shadow machine by one beat and return what the block must report
    function automatic flow_result_t step_flow(flow_cmd_t c);
        flow_result_t      r;
        logic [WORD_W-1:0] fall;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] word;
        fall    = shadow_pc + FALL_OFFSET;
        word    = '0;
        r.taken = 1'b0;
        case (c.action)
            ACT_JUMP: begin
                r.taken   = branch_taken(c.cond_code, c.zero_flag, c.sign_flag,
                                         c.overflow_flag);
                shadow_pc = r.taken ? c.target : fall;
            end
            ACT_CALL: begin
                // push the return address little-endian below the old SP
                shadow_sp = shadow_sp - FRAME_BYTES;
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    addr = shadow_sp + i;
                    shadow_stack[addr[ADDR_W-1:0]] = fall[8*i +: 8];
                end
                shadow_pc = c.target;
                r.taken   = 1'b1;
            end
            ACT_RET: begin
                // pop from the old SP; byte addresses wrap in the memory
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    addr = shadow_sp + i;
                    word[8*i +: 8] = shadow_stack[addr[ADDR_W-1:0]];
                end
                shadow_sp = shadow_sp + FRAME_BYTES;
                shadow_pc = word;
                r.taken   = 1'b1;
            end
            default: ;  // unused action: nothing moves
        endcase
        r.next_pc           = shadow_pc;
        r.new_stack_pointer = shadow_sp;
        return r;
    endfunction

    // --------------------------------------------------------------------
    // Stimulus helpers
    // --------------------------------------------------------------------

    function automatic stim_row_t make_row(logic [1:0] act, logic [3:0] cc,
                                           logic [WORD_W-1:0] tgt,
                                           logic zf, logic sf, logic of,
                                           bit typed = 1'b0,
                                           logic [WORD_W-1:0] pc = '0,
                                           logic [WORD_W-1:0] sp = '0,
                                           logic tk = 1'b0);
        stim_row_t row;
        row.cmd.action                 = act;
        row.cmd.cond_code              = cc;
        row.cmd.target                 = tgt;
        row.cmd.zero_flag              = zf;
        row.cmd.sign_flag              = sf;
        row.cmd.overflow_flag          = of;
        row.typed                      = typed;
        row.want.next_pc               = pc;
        row.want.new_stack_pointer     = sp;
        row.want.taken                 = tk;
        return row;
    endfunction

    // calls and returns in equal measure so returns mostly pop what calls pushed
    function automatic stim_row_t random_row();
        int                pick;
        logic [1:0]        act;
        logic [3:0]        cc;
        logic [WORD_W-1:0] tgt;
        pick = $urandom_range(99);
        if (pick < 8)
            act = ACT_NONE;
        else if (pick < 44)
            act = ACT_JUMP;
        else if (pick < 72)
            act = ACT_CALL;
        else
            act = ACT_RET;
        if ($urandom_range(99) < 80)
            cc = 4'($urandom_range(CC_G, CC_ALWAYS));
        else
            cc = 4'($urandom_range(CC_NEVER_LAST, CC_NEVER_FIRST));
        case ($urandom_range(9))
            0:       tgt = '0;
            1:       tgt = ALL_ONES;
            default: tgt = {$urandom, $urandom};
        endcase
        return make_row(act, cc, tgt, 1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
    endfunction

    // present one beat, at times after a random gap; valid stays high on return
    task automatic send_beat(stim_row_t row);
        flow_result_t predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.cmd.action;
        s_tdata  <= {1'b0, row.cmd.overflow_flag, row.cmd.sign_flag, row.cmd.zero_flag,
                     row.cmd.target, row.cmd.cond_code};
        do @(posedge aclk); while (!s_tready);
        predicted = step_flow(row.cmd);
        expected_flow_q.push_back(row.typed ? row.want : predicted);
    endtask

    // valid stays high on return so back-to-back writes need no toggle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_START_ADDRESS: begin
                shadow_start = value;
                shadow_pc    = value;
            end
            CFG_STACK_START: begin
                shadow_stack_start = value;
                shadow_sp          = value;
            end
            default: ;
        endcase
    endtask

    task automatic configure(logic [WORD_W-1:0] start_pc, logic [WORD_W-1:0] stack_top);
        write_reg(CFG_SPARE_LO, {$urandom, $urandom});
        write_reg(CFG_START_ADDRESS, start_pc);
        write_reg(CFG_STACK_START, stack_top);
        write_reg(CFG_SPARE_HI, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // hold the input off until every result is back and the block is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_flow_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // --------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // --------------------------------------------------------------------

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin : result_check
        flow_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_flow_q.size() == 0) begin
                $error("result beat with nothing pending: next_pc %h", m_tdata[63:0]);
                error_count++;
            end else begin
                want = expected_flow_q.pop_front();
                if (m_tdata[63:0] !== want.next_pc) begin
                    $error("next_pc: expected %h, got %h", want.next_pc, m_tdata[63:0]);
                    error_count++;
                end
                if (m_tdata[127:64] !== want.new_stack_pointer) begin
                    $error("new_stack_pointer: expected %h, got %h",
                           want.new_stack_pointer, m_tdata[127:64]);
                    error_count++;
                end
                if (m_tdata[128] !== want.taken) begin
                    $error("taken: expected %b, got %b", want.taken, m_tdata[128]);
                    error_count++;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------------

    initial begin : stimulus
        for (int a = 0; a < MEM_BYTES; a++)
            shadow_stack[a] = 8'h00;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, from the reset state PC = 0, SP = 0, stack cleared.
        // Typed rows: jump always to all-ones; never-taken code wrapping PC+9 to 8;
        // unused action; return from cleared stack; call pushing 9 at byte 0;
        // call to 0 from PC all-ones pushing 8 below SP 0, so the frame sits at the
        // top of memory; return popping it back; return popping the 9.
        directed_rows.push_back(make_row(ACT_JUMP, CC_ALWAYS, ALL_ONES, 0, 0, 0,
                                         1, ALL_ONES, 64'd0, 1));
        directed_rows.push_back(make_row(ACT_JUMP, CC_NEVER_LAST, 64'd0, 1, 1, 1,
                                         1, 64'd8, 64'd0, 0));
        directed_rows.push_back(make_row(ACT_NONE, CC_NEVER_LAST, ALL_ONES, 1, 1, 1,
                                         1, 64'd8, 64'd0, 0));
        directed_rows.push_back(make_row(ACT_RET, CC_ALWAYS, ALL_ONES, 0, 0, 0,
                                         1, 64'd0, 64'd8, 1));
        directed_rows.push_back(make_row(ACT_CALL, CC_NEVER_LAST, ALL_ONES, 1, 1, 1,
                                         1, ALL_ONES, 64'd0, 1));
        directed_rows.push_back(make_row(ACT_CALL, CC_ALWAYS, 64'd0, 0, 0, 0,
                                         1, 64'd0, 64'hFFFF_FFFF_FFFF_FFF8, 1));
        directed_rows.push_back(make_row(ACT_RET, CC_NEVER_LAST, ALL_ONES, 1, 1, 1,
                                         1, 64'd8, 64'd0, 1));
        directed_rows.push_back(make_row(ACT_RET, CC_ALWAYS, 64'd0, 0, 0, 0,
                                         1, 64'd9, 64'd8, 1));
        // conditions LE to G both taken and not, and a never-taken code, checked by the predictor
        directed_rows.push_back(make_row(ACT_JUMP, CC_LE, 64'hA5A5_A5A5_A5A5_A5A5, 1, 0, 0));
        directed_rows.push_back(make_row(ACT_JUMP, CC_LE, 64'h5A5A_5A5A_5A5A_5A5A, 0, 0, 0));
        directed_rows.push_back(make_row(ACT_JUMP, CC_L,  64'hA5A5_A5A5_A5A5_A5A5, 0, 1, 0));
        directed_rows.push_back(make_row(ACT_JUMP, CC_L,  64'h5A5A_5A5A_5A5A_5A5A, 0, 1, 1));
        directed_rows.push_back(make_row(ACT_JUMP, CC_E,  64'hA5A5_A5A5_A5A5_A5A5, 1, 0, 1));
        directed_rows.push_back(make_row(ACT_JUMP, CC_E,  64'h5A5A_5A5A_5A5A_5A5A, 0, 0, 1));
        directed_rows.push_back(make_row(ACT_JUMP, CC_NE, 64'hA5A5_A5A5_A5A5_A5A5, 0, 1, 1));
        directed_rows.push_back(make_row(ACT_JUMP, CC_NE, 64'h5A5A_5A5A_5A5A_5A5A, 1, 1, 1));
        directed_rows.push_back(make_row(ACT_JUMP, CC_GE, 64'hA5A5_A5A5_A5A5_A5A5, 0, 1, 1));
        directed_rows.push_back(make_row(ACT_JUMP, CC_GE, 64'h5A5A_5A5A_5A5A_5A5A, 0, 1, 0));
        directed_rows.push_back(make_row(ACT_JUMP, CC_G,  64'hA5A5_A5A5_A5A5_A5A5, 0, 0, 0));
        directed_rows.push_back(make_row(ACT_JUMP, CC_G,  64'h5A5A_5A5A_5A5A_5A5A, 1, 0, 0));
        directed_rows.push_back(make_row(ACT_JUMP, CC_NEVER_FIRST, ALL_ONES, 1, 0, 1));

        foreach (directed_rows[r])
            send_beat(directed_rows[r]);
        drain();

        // top of the address space: SP+8 and PC+9 both wrap
        configure(ALL_ONES, ALL_ONES);
        repeat (270) send_beat(random_row());
        drain();

        // stack straddling the end of memory, unaligned
        send_idle_pct = 87;
        recv_idle_pct = 34;
        configure(64'd0, 64'h0000_0000_0000_0FFD);
        repeat (270) send_beat(random_row());
        drain();

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure({$urandom, $urandom}, {$urandom, $urandom});
        repeat (260) send_beat(random_row());
        drain();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // guard against a hung handshake, including the clearing pass after reset
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

endmodule
